[hw/rtl/lge_pkg.sv]
// Shared types and constants for the Game of Life generation engine.
`timescale 1ns / 1ps
`default_nettype none

package lge_pkg;

    // Item and result field widths.
    localparam int CMD_W      = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;
    localparam int M_TUSER_W  = 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE   = 2'd2;
    localparam int CFG_DIM_RESET = 64;

    // Command codes carried in s_tuser.
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_READ_RD,
        ST_READ_OUT,
        ST_STEP_RD0,
        ST_STEP_RDLAST,
        ST_STEP_RD1,
        ST_STEP_CAPN,
        ST_STEP_CELL,
        ST_STEP_WB,
        ST_STEP_ADV,
        ST_STEP_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLR_WR,
        DP_TAKE,
        DP_ITEM_RD,
        DP_LOAD_WR,
        DP_OUT_READ,
        DP_S_RD0,
        DP_S_RDLAST,
        DP_S_RD1,
        DP_S_CAPN,
        DP_S_CELL,
        DP_S_WB,
        DP_S_ADV,
        DP_OUT_STEP
    } dp_op_t;

    typedef struct packed {
        logic clr_last;
        logic row_last;
        logic col_last;
        logic out_free;
        logic item_inside;
    } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/lge_ctrl.sv]
// Controller state machine that sequences clearing, item handling and generation steps.
`timescale 1ns / 1ps
`default_nettype none

module lge_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [lge_pkg::CMD_W-1:0]    item_cmd,
    input  wire lge_pkg::dp_status_t          status,
    output lge_pkg::dp_op_t                   op
);
    import lge_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = DP_NOP;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                op = DP_CLR_WR;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op = DP_TAKE;
                    unique case (item_cmd)
                        CMD_LOAD: begin
                            if (status.item_inside) begin
                                state_next = ST_LOAD_RD;
                            end
                        end
                        CMD_STEP: begin
                            state_next = ST_STEP_RD0;
                        end
                        CMD_READ: begin
                            // A read outside the grid skips the memory and returns zero.
                            state_next = status.item_inside ? ST_READ_RD : ST_READ_OUT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD_RD: begin
                op         = DP_ITEM_RD;
                state_next = ST_LOAD_WR;
            end
            ST_LOAD_WR: begin
                op         = DP_LOAD_WR;
                state_next = ST_IDLE;
            end
            ST_READ_RD: begin
                op         = DP_ITEM_RD;
                state_next = ST_READ_OUT;
            end
            ST_READ_OUT: begin
                if (status.out_free) begin
                    op         = DP_OUT_READ;
                    state_next = ST_IDLE;
                end
            end
            ST_STEP_RD0: begin
                op         = DP_S_RD0;
                state_next = ST_STEP_RDLAST;
            end
            ST_STEP_RDLAST: begin
                op         = DP_S_RDLAST;
                state_next = ST_STEP_RD1;
            end
            ST_STEP_RD1: begin
                op         = DP_S_RD1;
                state_next = ST_STEP_CAPN;
            end
            ST_STEP_CAPN: begin
                op         = DP_S_CAPN;
                state_next = ST_STEP_CELL;
            end
            ST_STEP_CELL: begin
                op = DP_S_CELL;
                if (status.col_last) begin
                    state_next = ST_STEP_WB;
                end
            end
            ST_STEP_WB: begin
                op         = DP_S_WB;
                state_next = status.row_last ? ST_STEP_OUT : ST_STEP_ADV;
            end
            ST_STEP_ADV: begin
                op         = DP_S_ADV;
                state_next = ST_STEP_CELL;
            end
            ST_STEP_OUT: begin
                if (status.out_free) begin
                    op         = DP_OUT_STEP;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/lge_datapath.sv]
// Datapath: configuration registers, row-wide cell memory, row window, neighbor rule and output register.
`timescale 1ns / 1ps
`default_nettype none

module lge_datapath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire lge_pkg::dp_op_t                   op,
    output lge_pkg::dp_status_t                    status,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lge_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lge_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic [lge_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [lge_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [lge_pkg::M_TUSER_W-1:0]          m_tuser
);
    import lge_pkg::*;

    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int COL_AW = $clog2(MAX_COLS);
    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int COL_CW = $clog2(MAX_COLS + 1);
    localparam int ROWS_RST = (CFG_DIM_RESET > MAX_ROWS) ? MAX_ROWS : CFG_DIM_RESET;
    localparam int COLS_RST = (CFG_DIM_RESET > MAX_COLS) ? MAX_COLS : CFG_DIM_RESET;

    // Configuration, dimensions stored already clamped to the legal range.
    logic [ROW_CW-1:0] nr_reg;
    logic [COL_CW-1:0] nc_reg;
    logic              wrap_reg;
    logic [ROW_CW-1:0] rows_clamped;
    logic [COL_CW-1:0] cols_clamped;

    // Item fields.
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic              in_val;
    logic [ROW_AW-1:0] item_row_reg;
    logic [COL_AW-1:0] item_col_reg;
    logic              item_val_reg;
    logic              item_inside_reg;

    // Cell memory: one word per grid row.
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic                mem_wr_en;
    logic [ROW_AW-1:0]   mem_wr_addr;
    logic [MAX_COLS-1:0] mem_wr_data;
    logic                mem_rd_en;
    logic [ROW_AW-1:0]   mem_rd_addr;
    logic [MAX_COLS-1:0] rd_data_reg;
    logic [MAX_COLS-1:0] load_word;

    // Row window for a generation step.
    logic [MAX_COLS-1:0] prev_row_reg;
    logic [MAX_COLS-1:0] cur_row_reg;
    logic [MAX_COLS-1:0] next_row_reg;
    logic [MAX_COLS-1:0] new_row_reg;
    logic [MAX_COLS-1:0] row0_row_reg;
    logic [ROW_AW-1:0]   row_cnt_reg;
    logic [COL_AW-1:0]   col_cnt_reg;
    logic [ROW_AW-1:0]   nr_m1;
    logic [COL_AW-1:0]   nc_m1;
    logic [ROW_AW-1:0]   row_inc;
    logic [ROW_AW-1:0]   row_ahead;
    logic [MAX_COLS-1:0] beyond_row;

    // Neighbor rule.
    logic [COL_AW-1:0] col_l;
    logic [COL_AW-1:0] col_r;
    logic              l_ok;
    logic              r_ok;
    logic [3:0]        nbr_cnt;
    logic              cell_new;

    // Output register.
    logic m_tvalid_reg;
    logic cell_alive_reg;
    logic step_done_reg;

    assign in_row = s_tdata[ROW_W-1:0];
    assign in_col = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_val = s_tdata[ROW_W+COL_W];

    always_comb begin
        if (cfg_wr_data == '0) begin
            rows_clamped = ROW_CW'(1);
            cols_clamped = COL_CW'(1);
        end else begin
            rows_clamped = (32'(cfg_wr_data) > MAX_ROWS) ? ROW_CW'(MAX_ROWS)
                                                          : ROW_CW'(cfg_wr_data);
            cols_clamped = (32'(cfg_wr_data) > MAX_COLS) ? COL_CW'(MAX_COLS)
                                                          : COL_CW'(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nr_reg   <= ROW_CW'(ROWS_RST);
            nc_reg   <= COL_CW'(COLS_RST);
            wrap_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROWS_IN_USE: nr_reg   <= rows_clamped;
                CFG_COLS_IN_USE: nc_reg   <= cols_clamped;
                CFG_WRAP_MODE:   wrap_reg <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign nr_m1     = ROW_AW'(nr_reg - ROW_CW'(1));
    assign nc_m1     = COL_AW'(nc_reg - COL_CW'(1));
    assign row_inc   = row_cnt_reg + ROW_AW'(1);
    assign row_ahead = row_cnt_reg + ROW_AW'(2);
    // The row past the last one is the saved old top row on a torus, empty otherwise.
    assign beyond_row = wrap_reg ? row0_row_reg : '0;

    always_comb begin
        status.clr_last    = (row_cnt_reg == ROW_AW'(MAX_ROWS - 1));
        status.row_last    = (row_cnt_reg == nr_m1);
        status.col_last    = (col_cnt_reg == nc_m1);
        status.out_free    = !m_tvalid_reg || m_tready;
        status.item_inside = (32'(in_row) < 32'(nr_reg)) && (32'(in_col) < 32'(nc_reg));
    end

    always_comb begin
        load_word               = rd_data_reg;
        load_word[item_col_reg] = item_val_reg;
    end

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = row_cnt_reg;
        mem_wr_data = new_row_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = item_row_reg;
        unique case (op)
            DP_CLR_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = '0;
            end
            DP_ITEM_RD: begin
                mem_rd_en = 1'b1;
            end
            DP_LOAD_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = item_row_reg;
                mem_wr_data = load_word;
            end
            DP_S_RD0: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
            end
            DP_S_RDLAST: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = nr_m1;
            end
            DP_S_RD1: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ROW_AW'(1);
            end
            DP_S_WB: begin
                // Write back the finished row and fetch the one two below it.
                mem_wr_en   = 1'b1;
                mem_rd_en   = 1'b1;
                mem_rd_addr = row_ahead;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    always_comb begin
        col_l = (col_cnt_reg == '0) ? nc_m1 : col_cnt_reg - COL_AW'(1);
        col_r = (col_cnt_reg == nc_m1) ? '0 : col_cnt_reg + COL_AW'(1);
        l_ok  = (col_cnt_reg != '0) || wrap_reg;
        r_ok  = (col_cnt_reg != nc_m1) || wrap_reg;
        nbr_cnt = 4'(prev_row_reg[col_l] & l_ok) + 4'(prev_row_reg[col_cnt_reg])
                + 4'(prev_row_reg[col_r] & r_ok) + 4'(cur_row_reg[col_l] & l_ok)
                + 4'(cur_row_reg[col_r] & r_ok)  + 4'(next_row_reg[col_l] & l_ok)
                + 4'(next_row_reg[col_cnt_reg])  + 4'(next_row_reg[col_r] & r_ok);
        cell_new = (nbr_cnt == 4'd3) || ((nbr_cnt == 4'd2) && cur_row_reg[col_cnt_reg]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else begin
            unique case (op)
                DP_CLR_WR: row_cnt_reg <= row_inc;
                DP_S_RD0: begin
                    row_cnt_reg <= '0;
                    col_cnt_reg <= '0;
                end
                DP_S_CELL: col_cnt_reg <= status.col_last ? '0 : col_cnt_reg + COL_AW'(1);
                DP_S_ADV:  row_cnt_reg <= row_inc;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (op)
            DP_TAKE: begin
                item_row_reg    <= ROW_AW'(in_row);
                item_col_reg    <= COL_AW'(in_col);
                item_val_reg    <= in_val;
                item_inside_reg <= status.item_inside;
            end
            DP_S_RDLAST: begin
                cur_row_reg  <= rd_data_reg;
                new_row_reg  <= rd_data_reg;
                row0_row_reg <= rd_data_reg;
            end
            DP_S_RD1: begin
                prev_row_reg <= wrap_reg ? rd_data_reg : '0;
            end
            DP_S_CAPN: begin
                next_row_reg <= status.row_last ? beyond_row : rd_data_reg;
            end
            DP_S_CELL: begin
                new_row_reg[col_cnt_reg] <= cell_new;
            end
            DP_S_WB: begin
                prev_row_reg <= cur_row_reg;
                cur_row_reg  <= next_row_reg;
                new_row_reg  <= next_row_reg;
            end
            DP_S_ADV: begin
                next_row_reg <= (row_inc == nr_m1) ? beyond_row : rd_data_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((op == DP_OUT_READ) || (op == DP_OUT_STEP)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == DP_OUT_READ) begin
            cell_alive_reg <= item_inside_reg & rd_data_reg[item_col_reg];
            step_done_reg  <= 1'b0;
        end else if (op == DP_OUT_STEP) begin
            cell_alive_reg <= 1'b0;
            step_done_reg  <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, cell_alive_reg};
    assign m_tuser  = step_done_reg;

endmodule

`default_nettype wire

[hw/rtl/life_generation_engine.sv]
// Top level of the Game of Life generation engine.
//
// The engine holds a MAX_ROWS x MAX_COLS grid of cells, one memory word per row, and
// applies rule B3/S23 over the area set by rows_in_use and cols_in_use, with either a
// toroidal edge or a dead border. After reset a clearing pass writes every row to dead,
// one row per cycle, so no item is accepted until that pass is done. Items are taken
// one at a time. A generation step is run by the cell sequencer, which evaluates one
// cell per cycle and, after each row, writes it back and fetches the row two below
// it on the single memory port pair. Items outside the area in use are ignored, and
// reads there return 0. A finished result waits in the output register while the
// next item is accepted; a read or step whose result finds that register still
// occupied waits until the receiver takes the older result.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_engine #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write port.
    input  wire logic                              cfg_wr_en,
    input  wire logic [lge_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lge_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // Input items.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lge_pkg::S_TDATA_W-1:0]     s_tdata,  // row[5:0], col[11:6], cell_value[12]
    input  wire logic [lge_pkg::S_TUSER_W-1:0]     s_tuser,  // cmd[1:0]
    // Result items.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [lge_pkg::M_TDATA_W-1:0]          m_tdata,  // cell_alive[0]
    output logic [lge_pkg::M_TUSER_W-1:0]          m_tuser   // step_done[0]
);
    import lge_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    lge_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .item_cmd (s_tuser),
        .status   (status),
        .op       (op)
    );

    lge_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire
